@@ design/svs_pkg.sv @@
// Shared types, constants and codes for the semblance velocity scan unit.
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

  // Store geometry
  localparam int MAX_VELOCITIES = 64;
  localparam int MAX_SAMPLES    = 1024;
  localparam int VEL_W          = $clog2(MAX_VELOCITIES);
  localparam int SMP_W          = $clog2(MAX_SAMPLES);
  localparam int ADDR_W         = VEL_W + SMP_W;

  // Shared multiplier operand width (signed)
  localparam int MUL_W = 34;

  // Register reset values
  localparam logic [10:0] SPT_RST = 11'd1000;
  localparam logic [6:0]  VC_RST  = 7'd50;
  localparam logic [31:0] FV_RST  = 32'd393216;
  localparam logic [31:0] VS_RST  = 32'd13107;
  localparam logic [31:0] SS_RST  = 32'd0;
  localparam logic [31:0] MF_RST  = 32'd52429;
  localparam logic [4:0]  DEC_RST = 5'd5;
  localparam logic [5:0]  SL_RST  = 6'd11;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_SPT = 3'd0,
    CFG_VC  = 3'd1,
    CFG_FV  = 3'd2,
    CFG_VS  = 3'd3,
    CFG_SS  = 3'd4,
    CFG_MF  = 3'd5,
    CFG_DEC = 3'd6,
    CFG_SL  = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MROOT,
    ST_VEL,
    ST_VDIV,
    ST_Q2,
    ST_TMI,
    ST_TMC,
    ST_IT,
    ST_TN2,
    ST_SQW,
    ST_TI,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_RMW,
    ST_RDWIN,
    ST_RDDAT,
    ST_RDMUL,
    ST_NORM,
    ST_FIN,
    ST_FDIV,
    ST_RESP
  } state_t;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } ds_mode_t;

  // Request to the shared divide / root unit
  typedef struct packed {
    logic        start;
    ds_mode_t    mode;
    logic [63:0] rad;
    logic [47:0] num;
    logic [47:0] den;
    logic [5:0]  steps;
  } ds_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] res;
  } ds_rsp_t;

endpackage

`default_nettype wire

@@ design/svs_if.sv @@
// Request and result channel interfaces of the semblance velocity scan unit.
`timescale 1ns / 1ps
`default_nettype none

interface svs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] sample_value;
  logic signed [31:0] source_offset;
  logic               last_of_trace;
  logic [5:0]         velocity_index;
  logic [9:0]         output_time_index;

  modport source (output valid, opcode, sample_value, source_offset, last_of_trace,
                  velocity_index, output_time_index, input ready);
  modport sink   (input valid, opcode, sample_value, source_offset, last_of_trace,
                  velocity_index, output_time_index, output ready);
endinterface

interface svs_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] semblance;
  logic        out_of_range;

  modport source (output valid, semblance, out_of_range, input ready);
  modport sink   (input valid, semblance, out_of_range, output ready);
endinterface

`default_nettype wire

@@ design/svs_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module svs_mul
  import svs_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  logic signed [2*MUL_W-1:0] p_r;

  // one product per cycle, ready the cycle after issue
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ design/svs_divsqrt.sv @@
// Shared iterative unit: restoring divide or digit-by-digit square root, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module svs_divsqrt
  import svs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  ds_req_t req,
  output ds_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  ds_mode_t    mode_r, mode_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [63:0] x_r, x_nxt;
  logic [47:0] den_r, den_nxt;
  logic [31:0] res_r, res_nxt;
  logic [48:0] dsh;
  logic [35:0] ssh;
  logic [35:0] trial;

  // step logic
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    rem_nxt  = rem_r;
    x_nxt    = x_r;
    den_nxt  = den_r;
    res_nxt  = res_r;
    dsh      = {rem_r, 1'b0};
    ssh      = {rem_r[33:0], x_r[63:62]};
    trial    = {2'b00, res_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      mode_nxt = req.mode;
      cnt_nxt  = req.steps;
      x_nxt    = req.rad;
      den_nxt  = req.den;
      res_nxt  = '0;
      rem_nxt  = (req.mode == DS_DIV) ? req.num : '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
      if (mode_r == DS_DIV) begin
        // remainder stays below the divisor
        if (dsh >= {1'b0, den_r}) begin
          rem_nxt = 48'(dsh - {1'b0, den_r});
          res_nxt = {res_r[30:0], 1'b1};
        end else begin
          rem_nxt = dsh[47:0];
          res_nxt = {res_r[30:0], 1'b0};
        end
      end else begin
        x_nxt = {x_r[61:0], 2'b00};
        if (ssh >= trial) begin
          rem_nxt = {12'b0, 36'(ssh - trial)};
          res_nxt = {res_r[30:0], 1'b1};
        end else begin
          rem_nxt = {12'b0, ssh};
          res_nxt = {res_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= DS_DIV;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    x_r   <= x_nxt;
    den_r <= den_nxt;
    res_r <= res_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

@@ design/semblance_velocity_scan_unit.sv @@
// Top level: sequencer, trace buffer and accumulator stores of the semblance velocity scan.
// Trace end: a root of the mute factor, then per velocity a divide and, for every time sample
//   from the mute on, a 32-step root in the shared divide/root unit.
// Read: a walk over the window samples, up to 57 normalising shifts and a divide.
// Clear: zeroes all 65536 store entries, one store entry a cycle; in ready is low meanwhile.
// Reset (synchronous, rst_n low) restores the registers and then runs the same clear.
`timescale 1ns / 1ps
`default_nettype none

module semblance_velocity_scan_unit
  import svs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  svs_in_if.sink           in_ch,
  svs_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // configuration registers
  logic [10:0] spt_r;
  logic [6:0]  vc_r;
  logic [31:0] fv_r;
  logic [31:0] vs_r;
  logic [31:0] ss_r;
  logic [31:0] mf_r;
  logic [4:0]  dec_r;
  logic [5:0]  sl_r;

  // control and datapath registers
  state_t       state_r, state_nxt;
  logic [10:0]  cnt_r, cnt_nxt;
  logic [31:0]  off_r, off_nxt;
  logic [31:0]  mag_r, mag_nxt;
  logic [24:0]  sqm_r, sqm_nxt;
  logic [6:0]   iv_r, iv_nxt;
  logic [37:0]  v_r, v_nxt;
  logic [31:0]  q_r, q_nxt;
  logic [63:0]  q2_r, q2_nxt;
  logic [10:0]  it_r, it_nxt;
  logic [9:0]   i_r, i_nxt;
  logic [15:0]  f_r, f_nxt;
  logic [49:0]  acc_r, acc_nxt;
  logic [32:0]  y_r, y_nxt;
  logic [15:0]  clr_r, clr_nxt;
  logic [5:0]   rv_r, rv_nxt;
  logic [10:0]  s_r, s_nxt;
  logic [10:0]  hi_r, hi_nxt;
  logic [103:0] n_r, n_nxt;
  logic [103:0] d_r, d_nxt;
  logic [47:0]  m_r, m_nxt;
  logic [63:0]  en_r, en_nxt;
  logic [15:0]  ct_r, ct_nxt;
  logic [2:0]   ph_r, ph_nxt;
  logic [16:0]  rsem_r, rsem_nxt;
  logic         roor_r, roor_nxt;
  logic         ovld_r, ovld_nxt;
  logic [16:0]  osem_r, osem_nxt;
  logic         ooor_r, ooor_nxt;

  // memories
  logic [31:0] buf_mem [MAX_SAMPLES];
  logic        buf_we;
  logic [9:0]  buf_ra;
  logic [31:0] buf_q_r;
  logic [47:0] st_mem [MAX_VELOCITIES*MAX_SAMPLES];
  logic [63:0] en_mem [MAX_VELOCITIES*MAX_SAMPLES];
  logic [15:0] ct_mem [MAX_VELOCITIES*MAX_SAMPLES];
  logic              sto_we;
  logic [ADDR_W-1:0] sto_wa;
  logic [ADDR_W-1:0] sto_ra;
  logic [47:0]       st_wd;
  logic [63:0]       en_wd;
  logic [15:0]       ct_wd;
  logic [47:0]       st_q_r;
  logic [63:0]       en_q_r;
  logic [15:0]       ct_q_r;

  // shared units
  ds_req_t                   ds_req;
  ds_rsp_t                   ds_rsp;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // derived values
  logic [10:0]  nt;
  logic [6:0]   nv;
  logic [4:0]   dec_e;
  logic [42:0]  tmd;
  logic [26:0]  tmute_d;
  logic [43:0]  tn;
  logic [43:0]  tn_neg;
  logic [31:0]  tn_abs;
  logic [64:0]  sum65;
  logic [33:0]  ti;
  logic [17:0]  ti_i1;
  logic [31:0]  xa, xb;
  logic [50:0]  x51;
  logic [50:0]  xr;
  logic [32:0]  y33;
  logic [48:0]  s49;
  logic [64:0]  e65;
  logic [14:0]  tdec;
  logic [4:0]   half;
  logic [15:0]  tdh;
  logic [47:0]  st_abs;
  logic [47:0]  prod;
  logic [ADDR_W-1:0] kaddr;
  logic [31:0]  in_abs;

  svs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  svs_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  // effective register values
  always_comb begin
    if (spt_r > 11'(MAX_SAMPLES)) begin
      nt = 11'(MAX_SAMPLES);
    end else if (spt_r == 11'd0) begin
      nt = 11'd1;
    end else begin
      nt = spt_r;
    end
    nv    = (vc_r > 7'(MAX_VELOCITIES)) ? 7'(MAX_VELOCITIES) : vc_r;
    dec_e = (dec_r == 5'd0) ? 5'd1 : dec_r;
  end

  // arithmetic around the shared units
  assign tmd     = 43'($signed({2'b00, mul_p[56:16]}) - $signed({{11{ss_r[31]}}, ss_r}));
  assign tmute_d = tmd[42:16];
  assign tn      = 44'($signed({{12{ss_r[31]}}, ss_r}) + $signed({17'b0, it_r, 16'b0}));
  assign tn_neg  = 44'(-tn);
  assign tn_abs  = tn[43] ? tn_neg[31:0] : tn[31:0];
  assign sum65   = {1'b0, mul_p[63:0]} + {1'b0, q2_r};
  assign ti      = 34'($signed({2'b00, ds_rsp.res}) - $signed({{2{ss_r[31]}}, ss_r}));
  assign ti_i1   = {1'b0, ti[32:16]} + 18'd1;
  assign xa      = ({1'b0, i_r} < cnt_r) ? buf_q_r : 32'd0;
  assign xb      = (11'({1'b0, i_r} + 11'd1) < cnt_r) ? buf_q_r : 32'd0;
  assign x51     = 51'($signed({acc_r[49], acc_r}) + $signed({mul_p[49], mul_p[49:0]}));
  assign xr      = 51'(x51 + 51'd32768);
  assign y33     = xr[48:16];
  assign s49     = 49'($signed({st_q_r[47], st_q_r}) + $signed({{16{y_r[32]}}, y_r}));
  assign e65     = {1'b0, en_q_r} + {1'b0, mul_p[63:0]};
  assign tdec    = 15'(in_ch.output_time_index * dec_e);
  assign half    = sl_r[5:1];
  assign tdh     = 16'(tdec + 15'(half));
  assign st_abs  = st_q_r[47] ? 48'(-st_q_r) : st_q_r;
  assign prod    = mul_p[47:0];
  assign kaddr   = {iv_r[VEL_W-1:0], it_r[SMP_W-1:0]};
  assign in_abs  = in_ch.source_offset[31] ? 32'(-in_ch.source_offset) :
                   in_ch.source_offset;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    mag_nxt   = mag_r;
    sqm_nxt   = sqm_r;
    iv_nxt    = iv_r;
    v_nxt     = v_r;
    q_nxt     = q_r;
    q2_nxt    = q2_r;
    it_nxt    = it_r;
    i_nxt     = i_r;
    f_nxt     = f_r;
    acc_nxt   = acc_r;
    y_nxt     = y_r;
    clr_nxt   = clr_r;
    rv_nxt    = rv_r;
    s_nxt     = s_r;
    hi_nxt    = hi_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    m_nxt     = m_r;
    en_nxt    = en_r;
    ct_nxt    = ct_r;
    ph_nxt    = ph_r;
    rsem_nxt  = rsem_r;
    roor_nxt  = roor_r;
    ovld_nxt  = ovld_r;
    osem_nxt  = osem_r;
    ooor_nxt  = ooor_r;
    buf_we    = 1'b0;
    buf_ra    = i_r;
    sto_we    = 1'b0;
    sto_wa    = kaddr;
    sto_ra    = kaddr;
    st_wd     = '0;
    en_wd     = '0;
    ct_wd     = '0;
    ds_req    = '0;
    mul_a     = '0;
    mul_b     = '0;

    // result leaves when taken
    if (ovld_r && out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (opcode_t'(in_ch.opcode))
            OP_SAMPLE: begin
              off_nxt = in_ch.source_offset;
              if (cnt_r < nt) begin
                buf_we  = 1'b1;
                cnt_nxt = cnt_r + 11'd1;
              end
              if (in_ch.last_of_trace) begin
                mag_nxt       = in_abs;
                iv_nxt        = '0;
                v_nxt         = {6'b0, fv_r};
                ds_req.start  = 1'b1;
                ds_req.mode   = DS_SQRT;
                ds_req.rad    = {16'b0, mf_r, 16'b0};
                ds_req.steps  = 6'd32;
                state_nxt     = ST_MROOT;
              end
            end
            OP_READ: begin
              rv_nxt = in_ch.velocity_index;
              if ({1'b0, in_ch.velocity_index} >= nv || tdec > 15'(nt - 11'd1)) begin
                rsem_nxt  = '0;
                roor_nxt  = 1'b1;
                state_nxt = ST_RESP;
              end else begin
                roor_nxt  = 1'b0;
                s_nxt     = (tdec >= 15'(half)) ? 11'(tdec - 15'(half)) : 11'd0;
                hi_nxt    = (tdh > 16'(nt - 11'd1)) ? 11'(nt - 11'd1) : tdh[10:0];
                n_nxt     = '0;
                d_nxt     = '0;
                state_nxt = ST_RDWIN;
              end
            end
            OP_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      // sweep every store entry back to zero
      ST_CLEAR: begin
        sto_we  = 1'b1;
        sto_wa  = clr_r;
        clr_nxt = clr_r + 16'd1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_MROOT: begin
        if (!ds_rsp.busy) begin
          sqm_nxt   = ds_rsp.res[24:0];
          state_nxt = ST_VEL;
        end
      end

      // per-velocity setup: offset over velocity
      ST_VEL: begin
        if (iv_r >= nv) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else if (v_r == 38'd0 || {6'b0, mag_r} >= v_r) begin
          iv_nxt = iv_r + 7'd1;
          v_nxt  = 38'(v_r + {6'b0, vs_r});
        end else begin
          ds_req.start = 1'b1;
          ds_req.mode  = DS_DIV;
          ds_req.num   = {16'b0, mag_r};
          ds_req.den   = {10'b0, v_r};
          ds_req.steps = 6'd32;
          state_nxt    = ST_VDIV;
        end
      end

      ST_VDIV: begin
        if (!ds_rsp.busy) begin
          q_nxt     = ds_rsp.res;
          state_nxt = ST_Q2;
        end
      end

      ST_Q2: begin
        mul_a     = {2'b00, q_r};
        mul_b     = {2'b00, q_r};
        state_nxt = ST_TMI;
      end

      ST_TMI: begin
        q2_nxt    = mul_p[63:0];
        mul_a     = {2'b00, q_r};
        mul_b     = {9'b0, sqm_r};
        state_nxt = ST_TMC;
      end

      // stretch mute start
      ST_TMC: begin
        if (!tmd[42] && tmd != 43'd0) begin
          it_nxt = (tmute_d > {16'b0, nt}) ? nt : tmute_d[10:0];
        end else begin
          it_nxt = '0;
        end
        state_nxt = ST_IT;
      end

      ST_IT: begin
        if (it_r >= nt) begin
          iv_nxt    = iv_r + 7'd1;
          v_nxt     = 38'(v_r + {6'b0, vs_r});
          state_nxt = ST_VEL;
        end else begin
          mul_a     = {2'b00, tn_abs};
          mul_b     = {2'b00, tn_abs};
          state_nxt = ST_TN2;
        end
      end

      ST_TN2: begin
        if (sum65[64]) begin
          it_nxt    = it_r + 11'd1;
          state_nxt = ST_IT;
        end else begin
          ds_req.start = 1'b1;
          ds_req.mode  = DS_SQRT;
          ds_req.rad   = sum65[63:0];
          ds_req.steps = 6'd32;
          state_nxt    = ST_SQW;
        end
      end

      ST_SQW: begin
        if (!ds_rsp.busy) begin
          state_nxt = ST_TI;
        end
      end

      // moveout time to buffer index and fraction
      ST_TI: begin
        if (ti[33] || ti_i1 >= {7'b0, nt}) begin
          it_nxt    = it_r + 11'd1;
          state_nxt = ST_IT;
        end else begin
          i_nxt     = ti[25:16];
          f_nxt     = ti[15:0];
          buf_ra    = ti[25:16];
          state_nxt = ST_RA;
        end
      end

      ST_RA: begin
        mul_a     = {17'b0, 17'({1'b1, 16'b0} - {1'b0, f_r})};
        mul_b     = {{2{xa[31]}}, xa};
        buf_ra    = 10'(i_r + 10'd1);
        state_nxt = ST_RB;
      end

      ST_RB: begin
        acc_nxt   = mul_p[49:0];
        mul_a     = {18'b0, f_r};
        mul_b     = {{2{xb[31]}}, xb};
        state_nxt = ST_RC;
      end

      ST_RC: begin
        if (y33 == 33'd0) begin
          it_nxt    = it_r + 11'd1;
          state_nxt = ST_IT;
        end else begin
          y_nxt     = y33;
          mul_a     = {y33[32], y33};
          mul_b     = {y33[32], y33};
          sto_ra    = kaddr;
          state_nxt = ST_RMW;
        end
      end

      // saturating accumulate into the stores
      ST_RMW: begin
        sto_we = 1'b1;
        sto_wa = kaddr;
        if (s49[48] != s49[47]) begin
          st_wd = s49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
          st_wd = s49[47:0];
        end
        en_wd     = e65[64] ? '1 : e65[63:0];
        ct_wd     = (ct_q_r == '1) ? ct_q_r : ct_q_r + 16'd1;
        it_nxt    = it_r + 11'd1;
        state_nxt = ST_IT;
      end

      // smoothing window walk
      ST_RDWIN: begin
        if (s_r >= hi_r) begin
          state_nxt = ST_NORM;
        end else begin
          sto_ra    = {rv_r, s_r[SMP_W-1:0]};
          state_nxt = ST_RDDAT;
        end
      end

      ST_RDDAT: begin
        m_nxt     = st_abs;
        en_nxt    = en_q_r;
        ct_nxt    = ct_q_r;
        ph_nxt    = '0;
        state_nxt = ST_RDMUL;
      end

      // partial products of stack^2 and count*energy
      ST_RDMUL: begin
        case (ph_r)
          3'd0: begin
            mul_a = {10'b0, m_r[47:24]};
            mul_b = {10'b0, m_r[47:24]};
          end
          3'd1: begin
            mul_a = {10'b0, m_r[47:24]};
            mul_b = {10'b0, m_r[23:0]};
            n_nxt = 104'(n_r + ({56'b0, prod} << 48));
          end
          3'd2: begin
            mul_a = {10'b0, m_r[23:0]};
            mul_b = {10'b0, m_r[23:0]};
            n_nxt = 104'(n_r + ({56'b0, prod} << 25));
          end
          3'd3: begin
            mul_a = {18'b0, ct_r};
            mul_b = {2'b00, en_r[31:0]};
            n_nxt = 104'(n_r + {56'b0, prod});
          end
          3'd4: begin
            mul_a = {18'b0, ct_r};
            mul_b = {2'b00, en_r[63:32]};
            d_nxt = 104'(d_r + {56'b0, prod});
          end
          default: begin
            d_nxt = 104'(d_r + ({56'b0, prod} << 32));
          end
        endcase
        if (ph_r == 3'd5) begin
          s_nxt     = s_r + 11'd1;
          state_nxt = ST_RDWIN;
        end else begin
          ph_nxt = ph_r + 3'd1;
        end
      end

      ST_NORM: begin
        if (|d_r[103:47]) begin
          n_nxt = n_r >> 1;
          d_nxt = d_r >> 1;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (d_r == '0) begin
          rsem_nxt  = '0;
          state_nxt = ST_RESP;
        end else if (n_r >= d_r) begin
          rsem_nxt  = {1'b1, 16'b0};
          state_nxt = ST_RESP;
        end else begin
          ds_req.start = 1'b1;
          ds_req.mode  = DS_DIV;
          ds_req.num   = n_r[47:0];
          ds_req.den   = d_r[47:0];
          ds_req.steps = 6'd16;
          state_nxt    = ST_FDIV;
        end
      end

      ST_FDIV: begin
        if (!ds_rsp.busy) begin
          rsem_nxt  = {1'b0, ds_rsp.res[15:0]};
          state_nxt = ST_RESP;
        end
      end

      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          osem_nxt  = rsem_r;
          ooor_nxt  = roor_r;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      off_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      off_r   <= off_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    sqm_r  <= sqm_nxt;
    iv_r   <= iv_nxt;
    v_r    <= v_nxt;
    q_r    <= q_nxt;
    q2_r   <= q2_nxt;
    it_r   <= it_nxt;
    i_r    <= i_nxt;
    f_r    <= f_nxt;
    acc_r  <= acc_nxt;
    y_r    <= y_nxt;
    rv_r   <= rv_nxt;
    s_r    <= s_nxt;
    hi_r   <= hi_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    en_r   <= en_nxt;
    ct_r   <= ct_nxt;
    ph_r   <= ph_nxt;
    rsem_r <= rsem_nxt;
    roor_r <= roor_nxt;
    osem_r <= osem_nxt;
    ooor_r <= ooor_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= SPT_RST;
      vc_r  <= VC_RST;
      fv_r  <= FV_RST;
      vs_r  <= VS_RST;
      ss_r  <= SS_RST;
      mf_r  <= MF_RST;
      dec_r <= DEC_RST;
      sl_r  <= SL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPT: spt_r <= cfg_data[10:0];
        CFG_VC:  vc_r  <= cfg_data[6:0];
        CFG_FV:  fv_r  <= cfg_data;
        CFG_VS:  vs_r  <= cfg_data;
        CFG_SS:  ss_r  <= cfg_data;
        CFG_MF:  mf_r  <= cfg_data;
        CFG_DEC: dec_r <= cfg_data[4:0];
        CFG_SL:  sl_r  <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // trace buffer
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[cnt_r[SMP_W-1:0]] <= in_ch.sample_value;
    end
    buf_q_r <= buf_mem[buf_ra];
  end

  // accumulator stores
  always_ff @(posedge clk) begin
    if (sto_we) begin
      st_mem[sto_wa] <= st_wd;
      en_mem[sto_wa] <= en_wd;
      ct_mem[sto_wa] <= ct_wd;
    end
    st_q_r <= st_mem[sto_ra];
    en_q_r <= en_mem[sto_ra];
    ct_q_r <= ct_mem[sto_ra];
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = ovld_r;
  assign out_ch.semblance = osem_r;
  assign out_ch.out_of_range = ooor_r;

endmodule

`default_nettype wire

@@ design/svs_chk.sv @@
// Port-level assertions for the semblance velocity scan unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module svs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] out_semblance,
  input wire logic        out_oor
);

  // reset starts the clearing sweep, so no request is taken next cycle
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request accepted straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_semblance) && $stable(out_oor))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_oor |-> out_semblance == 17'd0)
    else $error("out of range result with nonzero semblance");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_semblance <= 17'd65536)
    else $error("semblance above one");

  // results are produced only while the sequencer is busy
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared from idle");

endmodule

bind semblance_velocity_scan_unit svs_chk u_svs_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_semblance (out_ch.semblance),
  .out_oor       (out_ch.out_of_range)
);

`default_nettype wire

@@ sim/semblance_velocity_scan_unit_test.sv @@
// Self-checking testbench for the semblance velocity scan unit: directed and random requests.
`timescale 1ns / 1ps

module semblance_velocity_scan_unit_test;
  import svs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STORE_N = MAX_VELOCITIES * MAX_SAMPLES;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] val;
    logic [31:0] off;
    bit          last;
    bit [5:0]    vi;
    bit [9:0]    ti;
    bit          typed;
    bit [16:0]   sem;
    bit          oor;
  } stim_row_t;

  typedef struct {
    bit [16:0] sem;
    bit        oor;
  } semb_res_t;

  typedef struct {
    bit [10:0] spt;
    bit [6:0]  vc;
    bit [31:0] fv;
    bit [31:0] vs;
    bit [31:0] ss;
    bit [31:0] mf;
    bit [4:0]  dec;
    bit [5:0]  sl;
    int        items;
    int        max_len;
    bit        with_clear;
    bit        long_hold;
  } scan_setup_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  svs_in_if  req_if ();
  svs_out_if res_if ();

  semblance_velocity_scan_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow registers and stores of the scan
  bit [10:0] spt_r;
  bit [6:0]  vc_r;
  bit [31:0] fv_r, vs_r, ss_r, mf_r;
  bit [4:0]  dec_r;
  bit [5:0]  sl_r;
  longint           trace_mem [MAX_SAMPLES];
  longint unsigned  fill_cnt;
  longint           trace_off;
  longint           stack_acc [STORE_N];
  longint unsigned  energy_acc [STORE_N];
  bit [15:0]        hits_acc [STORE_N];

  semb_res_t semb_pending[$];
  int        err_cnt;
  longint    busy_bound;
  int        hold_req;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Integer square root, floor
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned eff_nt();
    longint unsigned n;
    n = (spt_r > MAX_SAMPLES) ? MAX_SAMPLES : spt_r;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic longint unsigned eff_nv();
    return (vc_r > MAX_VELOCITIES) ? MAX_VELOCITIES : vc_r;
  endfunction

  function automatic longint trace_at(longint unsigned i, longint unsigned have);
    return (i < have) ? trace_mem[i] : 0;
  endfunction

  function automatic void clear_stores();
    foreach (stack_acc[k]) begin
      stack_acc[k]  = 0;
      energy_acc[k] = 0;
      hits_acc[k]   = 0;
    end
  endfunction

  // Moveout-correct the gathered trace for every velocity and accumulate
  function automatic void stack_trace();
    longint unsigned nt, nv, have, mag, sqrtm, vel, q, q2, tm, d, itm;
    longint unsigned sum, idx, fr, k, sq, e, iv, it;
    longint ft, tn, ti, x, y, s, lim;
    nt    = eff_nt();
    nv    = eff_nv();
    have  = (fill_cnt < nt) ? fill_cnt : nt;
    ft    = longint'($signed(ss_r));
    mag   = longint'(trace_off < 0 ? -trace_off : trace_off);
    sqrtm = root64(longint'(mf_r) << 16);
    lim   = 64'sh8000_0000_0000;
    for (iv = 0; iv < nv; iv++) begin
      vel = longint'(fv_r) + iv * longint'(vs_r);
      if (vel == 0) continue;
      q = (mag << 32) / vel;
      if (q >= 64'h1_0000_0000) continue;
      q2  = q * q;
      tm  = (q * sqrtm) >> 16;
      itm = 0;
      if (longint'(tm) > ft) begin
        d   = longint'(longint'(tm) - ft) >> 16;
        itm = (d > nt) ? nt : d;
      end
      for (it = itm; it < nt; it++) begin
        tn  = ft + longint'(it << 16);
        sum = longint'(tn * tn) + q2;
        if (sum < q2) continue;
        ti = longint'(root64(sum)) - ft;
        if (ti < 0) continue;
        idx = longint'(ti) >> 16;
        if (idx + 1 >= nt) continue;
        fr = longint'(ti) & 64'hFFFF;
        x  = longint'(65536 - fr) * trace_at(idx, have) +
             longint'(fr) * trace_at(idx + 1, have);
        y  = (x + 32768) >>> 16;
        if (y == 0) continue;
        k  = iv * MAX_SAMPLES + it;
        s  = stack_acc[k] + y;
        if (s > lim - 1) s = lim - 1;
        if (s < -lim) s = -lim;
        stack_acc[k] = s;
        sq = longint'(y * y);
        e  = energy_acc[k] + sq;
        energy_acc[k] = (e < sq) ? 64'hFFFF_FFFF_FFFF_FFFF : e;
        if (hits_acc[k] != 16'hFFFF) hits_acc[k]++;
      end
    end
  endfunction

  // Windowed semblance quotient at one velocity and input time
  function automatic bit [16:0] semblance_at(longint unsigned iv, longint it0);
    longint nt, half, lo, hi, s, a;
    longint unsigned m, k;
    logic [127:0] num, den;
    nt   = longint'(eff_nt());
    half = sl_r / 2;
    lo   = it0 - half;
    hi   = it0 + half;
    num  = '0;
    den  = '0;
    if (lo < 0) lo = 0;
    if (hi > nt - 1) hi = nt - 1;
    for (s = lo; s < hi; s++) begin
      k   = iv * MAX_SAMPLES + longint'(s);
      a   = stack_acc[k];
      m   = longint'(a < 0 ? -a : a);
      num = num + {64'd0, m} * {64'd0, m};
      den = den + {112'd0, hits_acc[k]} * {64'd0, energy_acc[k]};
    end
    while (den[127:47] != 0) begin
      num >>= 1;
      den >>= 1;
    end
    if (den == 0) return 17'd0;
    if (num >= den) return 17'd65536;
    return 17'((num << 16) / den);
  endfunction

  // Apply one accepted request to the shadow state
  function automatic void apply_request(stim_row_t r);
    longint unsigned nt, nv, dec, ntout;
    semb_res_t res;
    nt = eff_nt();
    nv = eff_nv();
    case (r.op)
      OP_SAMPLE: begin
        trace_off = longint'($signed(r.val ^ r.val ^ r.off));
        if (fill_cnt < nt) begin
          trace_mem[fill_cnt] = longint'($signed(r.val));
          fill_cnt++;
        end
        if (r.last) begin
          stack_trace();
          fill_cnt   = 0;
          busy_bound = 36 + nv * (40 + 42 * nt) + 64;
        end else begin
          busy_bound = 8;
        end
      end
      OP_READ: begin
        dec   = (dec_r == 0) ? 1 : dec_r;
        ntout = 1 + (nt - 1) / dec;
        if (r.vi >= nv || r.ti >= ntout) begin
          res.sem = 0;
          res.oor = 1'b1;
        end else begin
          res.sem = semblance_at(r.vi, longint'(r.ti) * longint'(dec));
          res.oor = 1'b0;
        end
        if (r.typed) begin
          res.sem = r.sem;
          res.oor = r.oor;
        end
        semb_pending.push_back(res);
        busy_bound = 700;
      end
      OP_CLEAR: begin
        clear_stores();
        busy_bound = 65600;
      end
      default: ;
    endcase
  endfunction

  // Offer one request from a falling edge until it is taken
  task automatic offer(stim_row_t r);
    int gap;
    req_if.valid             <= 1'b1;
    req_if.opcode            <= r.op;
    req_if.sample_value      <= r.val;
    req_if.source_offset     <= r.off;
    req_if.last_of_trace     <= r.last;
    req_if.velocity_index    <= r.vi;
    req_if.output_time_index <= r.ti;
    do @(posedge clk); while (!req_if.ready);
    apply_request(r);
    @(negedge clk);
    gap = $urandom_range(0, 99);
    if (gap < 50) gap = 0;
    else if (gap < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Wait for every expected result, then for the block to go quiet
  task automatic settle();
    req_if.valid <= 1'b0;
    while (semb_pending.size() != 0) @(negedge clk);
    repeat (busy_bound) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_SPT: spt_r = data[10:0];
      CFG_VC:  vc_r  = data[6:0];
      CFG_FV:  fv_r  = data;
      CFG_VS:  vs_r  = data;
      CFG_SS:  ss_r  = data;
      CFG_MF:  mf_r  = data;
      CFG_DEC: dec_r = data[4:0];
      CFG_SL:  sl_r  = data[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(scan_setup_t p);
    write_reg(CFG_SPT, p.spt);
    write_reg(CFG_VC, p.vc);
    write_reg(CFG_FV, p.fv);
    write_reg(CFG_VS, p.vs);
    write_reg(CFG_SS, p.ss);
    write_reg(CFG_MF, p.mf);
    write_reg(CFG_DEC, p.dec);
    write_reg(CFG_SL, p.sl);
  endtask

  // Random traffic: mostly whole traces, with reads, noise and the odd clear
  task automatic random_traffic(scan_setup_t p);
    int n, trace_left, len, pick, nt_cap;
    stim_row_t r;
    logic [31:0] off;
    n          = 0;
    trace_left = 0;
    off        = 0;
    nt_cap     = (eff_nt() < p.max_len) ? eff_nt() : p.max_len;
    if (p.long_hold) hold_req = 1;
    while (n < p.items) begin
      r = '{default: '0};
      r.vi = $urandom;
      r.ti = $urandom;
      pick = $urandom_range(0, 99);
      if (p.with_clear && n == p.items / 2) begin
        r.op = OP_CLEAR;
      end else if (trace_left == 0 && pick < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = nt_cap;
        else if (pick < 85) len = $urandom_range(1, nt_cap);
        else len = nt_cap + $urandom_range(1, 4);
        trace_left = len;
        off = ($urandom_range(0, 99) < 3) ? $urandom : $urandom_range(0, 60);
        if ($urandom_range(0, 1)) off = -off;
        continue;
      end else if (trace_left > 0 && pick < 75) begin
        r.op   = OP_SAMPLE;
        r.val  = ($urandom_range(0, 99) < 5) ? $urandom :
                 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        r.off  = ($urandom_range(0, 99) < 5) ? $urandom : off;
        r.last = (trace_left == 1);
        trace_left--;
      end else if (pick < 95) begin
        r.op = OP_READ;
        if ($urandom_range(0, 99) < 80) begin
          r.vi = $urandom_range(0, eff_nv() - 1);
          r.ti = $urandom_range(0, (eff_nt() - 1) / ((dec_r == 0) ? 1 : dec_r));
        end
      end else begin
        r.op   = OP_UNUSED;
        r.val  = $urandom;
        r.off  = $urandom;
        r.last = $urandom;
      end
      offer(r);
      if (r.op != OP_UNUSED) n++;
      if (n == p.items / 3 && p.long_hold) settle();
    end
    settle();
  endtask

  // Result checker
  always @(posedge clk) begin
    semb_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (semb_pending.size() == 0) begin
        $display("%0t: unexpected result semblance=%0d out_of_range=%0b",
                 $time, res_if.semblance, res_if.out_of_range);
        err_cnt++;
      end else begin
        want = semb_pending.pop_front();
        if (res_if.semblance !== want.sem) begin
          $display("%0t: semblance expected %0d actual %0d",
                   $time, want.sem, res_if.semblance);
          err_cnt++;
        end
        if (res_if.out_of_range !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, want.oor, res_if.out_of_range);
          err_cnt++;
        end
      end
    end
  end

  // Result side back-pressure
  int burst_left, stall_left, hold_left;
  always @(negedge clk) begin
    int pick;
    if (hold_req != 0) begin
      hold_req  = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 4) burst_left = $urandom_range(5, 40);
      else if (pick < 9) stall_left = $urandom_range(1, 3);
      else stall_left = $urandom_range(20, 80);
      res_if.ready <= 1'b1;
    end
  end

  stim_row_t directed_rows [21] = '{
    '{OP_READ,   32'h0,        32'h0,        0, 0,  0,    1, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 63, 0,    1, 0, 1},
    '{OP_READ,   32'h0,        32'h0,        0, 3,  1023, 1, 0, 1},
    '{OP_READ,   32'h0,        32'h0,        0, 3,  11,   1, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 0,  12,   1, 0, 1},
    '{OP_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 63, 1023, 0, 0, 0},
    // huge moveout: nothing lands in the trace
    '{OP_SAMPLE, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0,  0,    0, 0, 0},
    '{OP_SAMPLE, 32'h80000000, 32'h80000000, 1, 0,  0,    0, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 0,  0,    0, 0, 0},
    // short trace at zero offset
    '{OP_SAMPLE, 32'h00010000, 32'h0,        0, 0,  0,    0, 0, 0},
    '{OP_SAMPLE, 32'hFFFF0000, 32'h0,        1, 0,  0,    0, 0, 0},
    // offset changes inside the trace, the last one counts
    '{OP_SAMPLE, 32'h00010000, 32'd20,       0, 0,  0,    0, 0, 0},
    '{OP_SAMPLE, 32'h00020000, 32'd20,       0, 0,  0,    0, 0, 0},
    '{OP_SAMPLE, 32'hFFFF0000, 32'hFFFFFFEC,  0, 0,  0,    0, 0, 0},
    '{OP_SAMPLE, 32'h7FFFFFFF, 32'hFFFFFFEC,  1, 0,  0,    0, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 0,  0,    0, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 1,  5,    0, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 3,  11,   0, 0, 0},
    '{OP_CLEAR,  32'h0,        32'h0,        0, 0,  0,    0, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 1,  5,    1, 0, 0},
    '{OP_READ,   32'h0,        32'h0,        0, 0,  1,    0, 0, 0}
  };

  scan_setup_t setups [6] = '{
    '{24,   4,  32'd393216,   32'd65536,    32'h0,        32'd52429,    2,  5,  150, 30, 0, 0},
    '{2,    64, 32'd1,        32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1,  63, 60,  4,  0, 0},
    '{1024, 1,  32'hFFFFFFFF, 32'h0,        32'h7FFFFFFF, 32'd1,        16, 1,  8,   3,  0, 0},
    '{0,    3,  32'h0,        32'd131072,   32'hFFFC8000, 32'd52429,    0,  11, 40,  3,  0, 0},
    '{40,   6,  32'd524288,   32'd32768,    32'd131072,   32'd52429,    3,  11, 250, 44, 1, 1},
    '{16,   8,  32'd262144,   32'd16384,    32'hFFFF0000, 32'd26214,    4,  7,  150, 20, 1, 0}
  };

  // Main sequence
  initial begin
    err_cnt    = 0;
    hold_req   = 0;
    burst_left = 0;
    stall_left = 0;
    hold_left  = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SPT;
    cfg_data   = '0;
    res_if.ready             = 1'b0;
    req_if.valid             = 1'b0;
    req_if.opcode            = OP_SAMPLE;
    req_if.sample_value      = '0;
    req_if.source_offset     = '0;
    req_if.last_of_trace     = 1'b0;
    req_if.velocity_index    = '0;
    req_if.output_time_index = '0;
    spt_r = SPT_RST;
    vc_r  = VC_RST;
    fv_r  = FV_RST;
    vs_r  = VS_RST;
    ss_r  = SS_RST;
    mf_r  = MF_RST;
    dec_r = DEC_RST;
    sl_r  = SL_RST;
    fill_cnt  = 0;
    trace_off = 0;
    clear_stores();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // the block clears its stores after reset
    busy_bound = 65600;
    settle();

    load_setup(setups[0]);
    foreach (directed_rows[i]) offer(directed_rows[i]);
    foreach (setups[p]) begin
      if (p > 0) load_setup(setups[p]);
      random_traffic(setups[p]);
    end

    settle();
    repeat (200) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #80_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ semblance_velocity_scan_unit.f @@
design/svs_pkg.sv
design/svs_if.sv
design/svs_mul.sv
design/svs_divsqrt.sv
design/semblance_velocity_scan_unit.sv
design/svs_chk.sv
sim/semblance_velocity_scan_unit_test.sv
